### src/mbrtu_pkg.sv
package mbrtu_pkg;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_BYTE  = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        IT_START = 2'd0,
        IT_BAD   = 2'd1,
        IT_BYTE  = 2'd2,
        IT_TICK  = 2'd3
    } t_item_kind;

    typedef struct packed {
        t_item_kind  kind;
        logic [7:0]  fc;
        logic [7:0]  id;
        logic [15:0] addr;
        logic [15:0] val;
        logic [7:0]  rx;
        logic [7:0]  exp_len;
    } t_item;

    typedef struct packed {
        logic [15:0] start_to;
        logic [15:0] byte_to;
        logic [15:0] gap;
        logic [2:0]  max_att;
        logic [5:0]  bitbuf;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx;
        logic [15:0] data;
        logic [2:0]  st;
        logic [7:0]  exc;
        logic        last;
    } t_result;

    localparam logic [1:0] K_TX   = 2'd0;
    localparam logic [1:0] K_DATA = 2'd1;
    localparam logic [1:0] K_STAT = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOREPLY = 3'd1;
    localparam logic [2:0] ST_PARTIAL = 3'd2;
    localparam logic [2:0] ST_IDFN    = 3'd3;
    localparam logic [2:0] ST_COUNT   = 3'd4;
    localparam logic [2:0] ST_CRC     = 3'd5;
    localparam logic [2:0] ST_EXC     = 3'd6;
    localparam logic [2:0] ST_BAD     = 3'd7;

    localparam logic [7:0] FC_COILS   = 8'h01;
    localparam logic [7:0] FC_INPUTS  = 8'h02;
    localparam logic [7:0] FC_HOLDING = 8'h03;
    localparam logic [7:0] FC_COIL_WR = 8'h05;
    localparam logic [7:0] FC_REG_WR  = 8'h06;

    localparam logic [2:0] CFG_START_TO = 3'd0;
    localparam logic [2:0] CFG_BYTE_TO  = 3'd1;
    localparam logic [2:0] CFG_GAP      = 3'd2;
    localparam logic [2:0] CFG_MAX_ATT  = 3'd3;
    localparam logic [2:0] CFG_BITBUF   = 3'd4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

### src/mbrtu_ram.sv
module mbrtu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/mbrtu_front.sv
module mbrtu_front import mbrtu_pkg::*; #(
    parameter int REG_BYTES = 128,
    parameter int BIT_BYTES = 32
) (
    input  logic        i_valid,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_function_code,
    input  logic [7:0]  i_slave_id,
    input  logic [15:0] i_address,
    input  logic [15:0] i_value,
    input  logic [7:0]  i_rx_byte,
    input  logic [5:0]  i_bitbuf,
    input  logic        i_q_ready,
    output logic        o_ready,
    output logic        o_push,
    output t_item       o_item
);

    logic [7:0] cnt;
    logic [9:0] exp_reg;
    logic [8:0] bc9;
    logic [5:0] bc;
    logic [9:0] exp_bit;
    logic       bad;
    logic [7:0] exp_len;
    logic       keep;
    t_item_kind kind;

    assign cnt     = i_value[7:0];
    assign exp_reg = 10'd5 + {1'b0, cnt, 1'b0};
    assign bc9     = {1'b0, cnt} + 9'd7;
    assign bc      = bc9[8:3];
    assign exp_bit = 10'd5 + {4'b0, bc};

    // request sizing, done once here so the back end only sees good/bad starts
    always_comb begin
        bad     = 1'b0;
        exp_len = 8'd8;
        case (i_function_code)
            FC_HOLDING: begin
                bad     = (exp_reg > 10'(REG_BYTES)) || (exp_reg > 10'd255);
                exp_len = exp_reg[7:0];
            end
            FC_COILS, FC_INPUTS: begin
                bad     = (cnt == 8'd0) || (bc > i_bitbuf) || (exp_bit > 10'(BIT_BYTES));
                exp_len = exp_bit[7:0];
            end
            FC_COIL_WR, FC_REG_WR: begin
                exp_len = 8'd8;
            end
            default: begin
                bad = 1'b1;
            end
        endcase
    end

    always_comb begin
        keep = 1'b1;
        kind = IT_TICK;
        unique case (t_mode'(i_mode))
            MODE_START: kind = bad ? IT_BAD : IT_START;
            MODE_BYTE:  kind = IT_BYTE;
            MODE_TICK:  kind = IT_TICK;
            MODE_NONE:  keep = 1'b0;
            default:    keep = 1'b0;
        endcase
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready && keep;

    assign o_item.kind    = kind;
    assign o_item.fc      = i_function_code;
    assign o_item.id      = i_slave_id;
    assign o_item.addr    = i_address;
    assign o_item.val     = i_value;
    assign o_item.rx      = i_rx_byte;
    assign o_item.exp_len = exp_len;

endmodule

### src/mbrtu_queue.sv
module mbrtu_queue import mbrtu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

### src/mbrtu_back.sv
module mbrtu_back import mbrtu_pkg::*; #(
    parameter int RAM_DEPTH = 128,
    parameter int AW        = 7
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_valid,
    input  t_item   i_item,
    output logic    o_pop,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_result o_out
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CRC  = 8'b0000_0010,
        S_TX   = 8'b0000_0100,
        S_EVAL = 8'b0000_1000,
        S_RDHI = 8'b0001_0000,
        S_RDLO = 8'b0010_0000,
        S_DAT  = 8'b0100_0000,
        S_STAT = 8'b1000_0000
    } t_state;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_FIRST = 4'b0010,
        PH_RECV  = 4'b0100,
        PH_GAP   = 4'b1000
    } t_phase;

    t_state      r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_req [8];
    logic [7:0]  n_req [8];
    logic [2:0]  r_cnt, n_cnt;
    logic [15:0] r_acc, n_acc;
    logic [7:0]  r_exp, n_exp;
    logic [7:0]  r_rcv, n_rcv;
    logic [15:0] r_rcrc, n_rcrc;
    logic [15:0] r_timer, n_timer;
    logic [2:0]  r_att, n_att;
    logic [7:0]  r_b0, n_b0, r_b1, n_b1, r_b2, n_b2;
    logic [7:0]  r_clo, n_clo, r_chi, n_chi;
    logic [2:0]  r_st, n_st;
    logic [7:0]  r_exc, n_exc;
    logic [7:0]  r_ptr, n_ptr;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_hi, n_hi;
    t_result     r_out, n_out;
    logic        r_ov;
    logic        load;
    logic        emit_ok;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic [2:0]  lim;
    logic [15:0] t_inc;
    logic [2:0]  att_inc;
    logic [15:0] crc_a;
    logic [7:0]  fc, cnt;
    logic [8:0]  bc9;
    logic [7:0]  bc;
    logic [7:0]  ptr_nx;
    logic        is_hold, is_bits;
    logic [7:0]  b1_nx;
    logic [7:0]  rcv_nx;
    logic        fail, resend;

    assign lim     = (i_cfg.max_att == 3'd0) ? 3'd1 : i_cfg.max_att;
    assign t_inc   = (r_timer == 16'hFFFF) ? r_timer : r_timer + 16'd1;
    assign att_inc = r_att + 3'd1;
    assign crc_a   = crc_step(r_acc, r_req[r_cnt]);
    assign fc      = r_req[1];
    assign cnt     = r_req[5];
    assign bc9     = {1'b0, cnt} + 9'd7;
    assign bc      = {2'b00, bc9[8:3]};
    assign ptr_nx  = r_ptr + 8'd1;
    assign is_hold = (fc == FC_HOLDING);
    assign is_bits = (fc == FC_COILS) || (fc == FC_INPUTS);
    assign emit_ok = !r_ov || i_out_ready;
    assign b1_nx   = (r_rcv == 8'd1) ? i_item.rx : r_b1;
    assign rcv_nx  = (r_rcv < r_exp) ? r_rcv + 8'd1 : r_rcv;

    assign ram_we = o_pop && (i_item.kind == IT_BYTE) &&
                    (r_phase == PH_FIRST || r_phase == PH_RECV) && (r_rcv < r_exp);

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_req   = r_req;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_exp   = r_exp;
        n_rcv   = r_rcv;
        n_rcrc  = r_rcrc;
        n_timer = r_timer;
        n_att   = r_att;
        n_b0    = r_b0;
        n_b1    = r_b1;
        n_b2    = r_b2;
        n_clo   = r_clo;
        n_chi   = r_chi;
        n_st    = r_st;
        n_exc   = r_exc;
        n_ptr   = r_ptr;
        n_left  = r_left;
        n_hi    = r_hi;
        n_out   = r_out;
        load    = 1'b0;
        o_pop   = 1'b0;
        ram_re  = 1'b0;
        ram_raddr = r_ptr[AW-1:0];
        fail    = 1'b0;
        resend  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    case (i_item.kind)
                        IT_START: begin
                            if (r_phase == PH_IDLE) begin
                                n_req[0] = i_item.id;
                                n_req[1] = i_item.fc;
                                n_req[2] = i_item.addr[15:8];
                                n_req[3] = i_item.addr[7:0];
                                n_req[4] = (i_item.fc == FC_COIL_WR || i_item.fc == FC_REG_WR)
                                           ? i_item.val[15:8] : 8'h00;
                                n_req[5] = i_item.val[7:0];
                                n_acc    = CRC_INIT;
                                n_cnt    = 3'd0;
                                n_exp    = i_item.exp_len;
                                n_att    = 3'd0;
                                n_state  = S_CRC;
                            end
                        end
                        IT_BAD: begin
                            if (r_phase == PH_IDLE) begin
                                n_st    = ST_BAD;
                                n_exc   = 8'h00;
                                n_state = S_STAT;
                            end
                        end
                        IT_BYTE: begin
                            if (r_phase == PH_FIRST || r_phase == PH_RECV) begin
                                if (r_rcv < r_exp) begin
                                    if ({1'b0, r_rcv} + 9'd2 < {1'b0, r_exp}) begin
                                        n_rcrc = crc_step(r_rcrc, i_item.rx);
                                    end
                                    if (r_rcv == 8'd0) n_b0 = i_item.rx;
                                    if (r_rcv == 8'd1) n_b1 = i_item.rx;
                                    if (r_rcv == 8'd2) n_b2 = i_item.rx;
                                    if (r_rcv == r_exp - 8'd2) n_clo = i_item.rx;
                                    if (r_rcv == r_exp - 8'd1) n_chi = i_item.rx;
                                end
                                n_rcv   = rcv_nx;
                                n_phase = PH_RECV;
                                n_timer = 16'd0;
                                // exception replies are complete after five bytes
                                if (rcv_nx >= r_exp || (rcv_nx == 8'd5 && b1_nx[7])) begin
                                    n_phase = PH_IDLE;
                                    n_state = S_EVAL;
                                end
                            end
                        end
                        IT_TICK: begin
                            if (r_phase != PH_IDLE) begin
                                n_timer = t_inc;
                                if (r_phase == PH_FIRST) begin
                                    fail = (t_inc >= i_cfg.start_to);
                                end else if (r_phase == PH_RECV) begin
                                    fail = (t_inc >= i_cfg.byte_to);
                                end else begin
                                    resend = (t_inc >= i_cfg.gap);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                if (fail) begin
                    n_att = att_inc;
                    if (att_inc >= lim) begin
                        n_st    = (r_rcv != 8'd0) ? ST_PARTIAL : ST_NOREPLY;
                        n_exc   = 8'h00;
                        n_phase = PH_IDLE;
                        n_state = S_STAT;
                    end else if (i_cfg.gap == 16'd0) begin
                        resend = 1'b1;
                    end else begin
                        n_phase = PH_GAP;
                        n_timer = 16'd0;
                    end
                end
                if (resend) begin
                    n_cnt   = 3'd0;
                    n_state = S_TX;
                    n_phase = PH_FIRST;
                    n_timer = 16'd0;
                    n_rcv   = 8'd0;
                    n_rcrc  = CRC_INIT;
                end
            end
            S_CRC: begin
                n_acc = crc_a;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd5) begin
                    n_req[6] = crc_a[7:0];
                    n_req[7] = crc_a[15:8];
                    n_cnt    = 3'd0;
                    n_state  = S_TX;
                    n_phase  = PH_FIRST;
                    n_timer  = 16'd0;
                    n_rcv    = 8'd0;
                    n_rcrc   = CRC_INIT;
                end
            end
            S_TX: begin
                if (emit_ok) begin
                    load  = 1'b1;
                    n_out = '{kind: K_TX, tx: r_req[r_cnt], data: 16'h0, st: ST_OK,
                              exc: 8'h00, last: 1'b0};
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EVAL: begin
                n_exc   = 8'h00;
                n_state = S_STAT;
                if (r_b0 != r_req[0] || r_b1 != fc) begin
                    n_st  = r_b1[7] ? ST_EXC : ST_IDFN;
                    n_exc = r_b1[7] ? r_b2 : 8'h00;
                end else if (is_hold && r_b2 != {cnt[6:0], 1'b0}) begin
                    n_st = ST_COUNT;
                end else if (is_bits && r_b2 != bc) begin
                    n_st = ST_COUNT;
                end else if ({r_chi, r_clo} != r_rcrc) begin
                    n_st = ST_CRC;
                end else begin
                    n_st   = ST_OK;
                    n_ptr  = 8'd3;
                    n_left = is_hold ? cnt : (is_bits ? bc : 8'd0);
                    if ((is_hold && cnt != 8'd0) || is_bits) begin
                        n_state = S_RDHI;
                    end
                end
            end
            S_RDHI: begin
                ram_re    = 1'b1;
                ram_raddr = r_ptr[AW-1:0];
                n_state   = is_hold ? S_RDLO : S_DAT;
            end
            S_RDLO: begin
                n_hi      = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = ptr_nx[AW-1:0];
                n_state   = S_DAT;
            end
            S_DAT: begin
                if (emit_ok) begin
                    load   = 1'b1;
                    n_out  = '{kind: K_DATA, tx: 8'h00,
                               data: is_hold ? {r_hi, ram_rdata} : {8'h00, ram_rdata},
                               st: ST_OK, exc: 8'h00, last: 1'b0};
                    n_ptr  = r_ptr + (is_hold ? 8'd2 : 8'd1);
                    n_left = r_left - 8'd1;
                    n_state = (r_left == 8'd1) ? S_STAT : S_RDHI;
                end
            end
            S_STAT: begin
                if (emit_ok) begin
                    load    = 1'b1;
                    n_out   = '{kind: K_STAT, tx: 8'h00, data: 16'h0, st: r_st,
                                exc: r_exc, last: 1'b1};
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_IDLE;
            r_ov    <= 1'b0;
            r_exp   <= 8'd0;
            r_rcv   <= 8'd0;
            r_rcrc  <= CRC_INIT;
            r_timer <= 16'd0;
            r_att   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_exp   <= n_exp;
            r_rcv   <= n_rcv;
            r_rcrc  <= n_rcrc;
            r_timer <= n_timer;
            r_att   <= n_att;
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_b0   <= n_b0;
        r_b1   <= n_b1;
        r_b2   <= n_b2;
        r_clo  <= n_clo;
        r_chi  <= n_chi;
        r_st   <= n_st;
        r_exc  <= n_exc;
        r_ptr  <= n_ptr;
        r_left <= n_left;
        r_hi   <= n_hi;
        r_out  <= n_out;
    end

    mbrtu_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH),
        .AW    (AW)
    ) u_reply_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_rcv[AW-1:0]),
        .i_wdata (i_item.rx),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    a_rcv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_rcv <= r_exp))
        else $error("reply count past expected length");

    a_tx_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TX) |-> (r_phase == PH_FIRST))
        else $error("request sent outside first-byte wait");

    a_att_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_att < lim))
        else $error("exchange active with attempts used up");

endmodule

### src/modbus_rtu_master_exchange_unit.sv
// Modbus RTU master exchange. A start transfer (function 1, 2, 3, 5 or 6) builds
// an 8-byte request with CRC-16 appended low byte first and sends it as eight
// transmit results; reply bytes and 1 ms tick transfers then drive the reply
// collection, start and inter-byte timeouts and retries after a recovery gap.
// The run ends with data words (register reads) or coil/input bytes, then one
// status result with last set. Unsupported functions, zero-count bit reads or
// oversized reads end at once with status 7. Input transfers go through a
// classifier into a 2-entry queue; a sequencer works off one queued item at a
// time. A byte or tick is dequeued and processed in the idle state; a start
// then runs the CRC over the six request bytes (one byte per cycle) and sends
// the eight transmit results, which a resend tick sends again; a complete
// reply passes a check state, then per coil byte a RAM read and an output
// state, per register word two RAM reads and an output state, then status.
// While a result waits in its output register, input still enters the queue
// until it is full. Configuration writes must happen while the block is idle.
module modbus_rtu_master_exchange_unit import mbrtu_pkg::*; #(
    parameter int REG_REPLY_BYTES = 128,
    parameter int BIT_REPLY_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_function_code,
    input  logic [7:0]  i_slave_id,
    input  logic [15:0] i_address,
    input  logic [15:0] i_value,
    input  logic [7:0]  i_rx_byte,
    // result item
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic [15:0] o_data_value,
    output logic [2:0]  o_status,
    output logic [7:0]  o_exception_code,
    output logic        o_last,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    // reply RAM covers the larger of the two reply limits
    localparam int RAM_DEPTH = (REG_REPLY_BYTES > BIT_REPLY_BYTES) ?
                               REG_REPLY_BYTES : BIT_REPLY_BYTES;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    t_cfg    r_cfg;
    t_item   push_item;
    t_item   q_item;
    t_result res;
    logic    push, q_ready, q_valid, pop;

    // config registers, reset to the documented defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_to <= 16'd350;
            r_cfg.byte_to  <= 16'd25;
            r_cfg.gap      <= 16'd12;
            r_cfg.max_att  <= 3'd2;
            r_cfg.bitbuf   <= 6'd32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_TO: r_cfg.start_to <= i_cfg_data;
                CFG_BYTE_TO:  r_cfg.byte_to  <= i_cfg_data;
                CFG_GAP:      r_cfg.gap      <= i_cfg_data;
                CFG_MAX_ATT:  r_cfg.max_att  <= i_cfg_data[2:0];
                CFG_BITBUF:   r_cfg.bitbuf   <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    // front: classify and size the transfer
    mbrtu_front #(
        .REG_BYTES (REG_REPLY_BYTES),
        .BIT_BYTES (BIT_REPLY_BYTES)
    ) u_front (
        .i_valid         (i_valid),
        .i_mode          (i_mode),
        .i_function_code (i_function_code),
        .i_slave_id      (i_slave_id),
        .i_address       (i_address),
        .i_value         (i_value),
        .i_rx_byte       (i_rx_byte),
        .i_bitbuf        (r_cfg.bitbuf),
        .i_q_ready       (q_ready),
        .o_ready         (o_ready),
        .o_push          (push),
        .o_item          (push_item)
    );

    // short queue decoupling front and sequencer
    mbrtu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // back: exchange sequencer, reply RAM and output register
    mbrtu_back #(
        .RAM_DEPTH (RAM_DEPTH),
        .AW        (RAM_AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_item      (q_item),
        .o_pop       (pop),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_out       (res)
    );

    assign o_kind           = res.kind;
    assign o_tx_byte        = res.tx;
    assign o_data_value     = res.data;
    assign o_status         = res.st;
    assign o_exception_code = res.exc;
    assign o_last           = res.last;

endmodule

### tb/sv/tb_modbus_rtu_master_exchange_unit.sv
module tb_modbus_rtu_master_exchange_unit;
    import mbrtu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Reply buffer sizes as built into the block
    localparam int REG_MAX = 128;
    localparam int BIT_MAX = 32;
    localparam int CYCLE_LIMIT = 3_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_mode = MODE_NONE;
    logic [7:0]  i_function_code = '0;
    logic [7:0]  i_slave_id = '0;
    logic [15:0] i_address = '0;
    logic [15:0] i_value = '0;
    logic [7:0]  i_rx_byte = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_tx_byte;
    logic [15:0] o_data_value;
    logic [2:0]  o_status;
    logic [7:0]  o_exception_code;
    logic        o_last;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    modbus_rtu_master_exchange_unit i_dut (.*);

    always #1 i_clk = ~i_clk;

    // Predictor state: configuration copy
    logic [15:0] cf_start_to, cf_byte_to, cf_gap;
    logic [2:0]  cf_max_att;
    logic [5:0]  cf_bitbuf;
    // Predictor state: exchange
    typedef enum logic [1:0] {X_IDLE, X_FIRST, X_RECV, X_GAP} t_xphase;
    t_xphase     x_phase;
    logic [7:0]  x_req [8];
    logic [7:0]  x_reply [256];
    int unsigned x_rcvd, x_len;
    logic [15:0] x_crc, x_timer;
    logic [2:0]  x_att;

    t_result expected_results[$];

    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_status = 0;
    longint cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    logic [7:0] cur_id;

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH result %0d: %s", n_results, what);
    endtask

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++) x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
        return x;
    endfunction

    function automatic void push_result(input logic [1:0] k, input logic [7:0] tx,
                                        input logic [15:0] d, input logic [2:0] st,
                                        input logic [7:0] ex, input logic lst);
        t_result r;
        r.kind = k; r.tx = tx; r.data = d; r.st = st; r.exc = ex; r.last = lst;
        expected_results.push_back(r);
    endfunction

    function automatic void end_exchange(input logic [2:0] st, input logic [7:0] ex);
        x_phase = X_IDLE;
        push_result(K_STAT, 8'h00, 16'h0000, st, ex, 1'b1);
    endfunction

    function automatic void transmit_request();
        for (int i = 0; i < 8; i++) push_result(K_TX, x_req[i], 16'h0, ST_OK, 8'h0, 1'b0);
        x_phase = X_FIRST; x_timer = 0; x_rcvd = 0; x_crc = CRC_INIT;
    endfunction

    function automatic void attempt_failed();
        logic [2:0] err;
        int unsigned lim;
        err = (x_rcvd != 0) ? ST_PARTIAL : ST_NOREPLY;
        lim = (cf_max_att != 0) ? cf_max_att : 1;
        x_att = x_att + 3'd1;
        if (x_att >= lim) end_exchange(err, 8'h00);
        else if (cf_gap == 0) transmit_request();
        else begin
            x_phase = X_GAP; x_timer = 0;
        end
    endfunction

    function automatic void check_reply();
        logic [7:0] fc, cnt;
        int unsigned n;
        logic [15:0] got;
        fc = x_req[1]; cnt = x_req[5];
        if (x_reply[0] != x_req[0] || x_reply[1] != fc) begin
            if (x_reply[1][7]) end_exchange(ST_EXC, x_reply[2]);
            else end_exchange(ST_IDFN, 8'h00);
            return;
        end
        n = 0;
        if (fc == FC_HOLDING) begin
            n = cnt;
            if (x_reply[2] != 8'(cnt * 2)) begin
                end_exchange(ST_COUNT, 8'h00); return;
            end
        end else if (fc == FC_COILS || fc == FC_INPUTS) begin
            n = (cnt + 7) / 8;
            if (x_reply[2] != 8'(n)) begin
                end_exchange(ST_COUNT, 8'h00); return;
            end
        end
        got = {x_reply[8'(x_len - 1)], x_reply[8'(x_len - 2)]};
        if (got != x_crc) begin
            end_exchange(ST_CRC, 8'h00); return;
        end
        for (int i = 0; i < n; i++) begin
            if (fc == FC_HOLDING)
                push_result(K_DATA, 8'h0, {x_reply[8'(3 + 2 * i)], x_reply[8'(4 + 2 * i)]},
                            ST_OK, 8'h0, 1'b0);
            else
                push_result(K_DATA, 8'h0, {8'h00, x_reply[8'(3 + i)]}, ST_OK, 8'h0, 1'b0);
        end
        end_exchange(ST_OK, 8'h00);
    endfunction

    // Expected results of one accepted input transfer
    function automatic void predict_exchange(input logic [1:0] md, input logic [7:0] fc,
                                             input logic [7:0] id, input logic [15:0] ad,
                                             input logic [15:0] vl, input logic [7:0] rx);
        int unsigned len, bc;
        logic [15:0] c;
        case (md)
            MODE_START: begin
                if (x_phase != X_IDLE) return;
                if (fc == FC_HOLDING) begin
                    len = 5 + 2 * vl[7:0];
                    if (len > REG_MAX) begin
                        end_exchange(ST_BAD, 8'h0); return;
                    end
                end else if (fc == FC_COILS || fc == FC_INPUTS) begin
                    bc = (vl[7:0] + 7) / 8;
                    len = 5 + bc;
                    if (vl[7:0] == 0 || bc > cf_bitbuf || len > BIT_MAX) begin
                        end_exchange(ST_BAD, 8'h0); return;
                    end
                end else if (fc == FC_COIL_WR || fc == FC_REG_WR) len = 8;
                else begin
                    end_exchange(ST_BAD, 8'h0); return;
                end
                if (len > 255) begin
                    end_exchange(ST_BAD, 8'h0); return;
                end
                x_req[0] = id; x_req[1] = fc; x_req[2] = ad[15:8]; x_req[3] = ad[7:0];
                x_req[4] = (fc == FC_COIL_WR || fc == FC_REG_WR) ? vl[15:8] : 8'h00;
                x_req[5] = vl[7:0];
                c = CRC_INIT;
                for (int i = 0; i < 6; i++) c = crc_byte(c, x_req[i]);
                x_req[6] = c[7:0]; x_req[7] = c[15:8];
                x_len = len; x_att = 0;
                transmit_request();
            end
            MODE_BYTE: begin
                if (x_phase != X_FIRST && x_phase != X_RECV) return;
                if (x_rcvd < x_len && x_rcvd < 256) begin
                    x_reply[x_rcvd] = rx;
                    if (x_rcvd + 2 < x_len) x_crc = crc_byte(x_crc, rx);
                    x_rcvd++;
                end
                x_phase = X_RECV; x_timer = 0;
                if (x_rcvd >= x_len || (x_rcvd == 5 && x_reply[1][7])) check_reply();
            end
            MODE_TICK: begin
                if (x_phase == X_IDLE) return;
                if (x_timer != 16'hFFFF) x_timer++;
                if (x_phase == X_FIRST) begin
                    if (x_timer >= cf_start_to) attempt_failed();
                end else if (x_phase == X_RECV) begin
                    if (x_timer >= cf_byte_to) attempt_failed();
                end else if (x_timer >= cf_gap) transmit_request();
            end
            default: ;
        endcase
    endfunction

    // One input transfer: drive at the falling edge, wait for acceptance
    task automatic send_item(input logic [1:0] md, input logic [7:0] fc = 0,
                             input logic [7:0] id = 0, input logic [15:0] ad = 0,
                             input logic [15:0] vl = 0, input logic [7:0] rx = 0);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_valid = 1'b1; i_mode <= md; i_function_code <= fc; i_slave_id <= id;
        i_address <= ad; i_value <= vl; i_rx_byte <= rx;
        do @(posedge i_clk); while (!o_ready);
        predict_exchange(md, fc, id, ad, vl, rx);
        n_items++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] d);
        i_cfg_we = 1'b1; i_cfg_idx <= idx; i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_START_TO: cf_start_to = d;
            CFG_BYTE_TO:  cf_byte_to = d;
            CFG_GAP:      cf_gap = d;
            CFG_MAX_ATT:  cf_max_att = d[2:0];
            CFG_BITBUF:   cf_bitbuf = d[5:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] st, input logic [15:0] bt,
                              input logic [15:0] gp, input logic [2:0] ma,
                              input logic [5:0] bb);
        wait_drained();
        write_reg(CFG_START_TO, st); write_reg(CFG_BYTE_TO, bt);
        write_reg(CFG_GAP, gp); write_reg(CFG_MAX_ATT, ma); write_reg(CFG_BITBUF, bb);
    endtask

    // A slave reply matching the current request, optionally corrupted
    task automatic send_reply(input logic [7:0] fc, input logic [7:0] cnt, input int flaw);
        logic [7:0] b [$];
        logic [15:0] c;
        int unsigned n;
        b.push_back(cur_id);
        if (flaw == 1) b[0] = cur_id ^ 8'h01;
        if (flaw == 2) begin
            b.push_back(fc | 8'h80); b.push_back(8'($urandom));
            b.push_back(8'($urandom)); b.push_back(8'($urandom));
        end else begin
            b.push_back(fc);
            if (fc == FC_HOLDING || fc == FC_COILS || fc == FC_INPUTS) begin
                n = (fc == FC_HOLDING) ? 2 * cnt : (cnt + 7) / 8;
                b.push_back((flaw == 3) ? 8'(n + 1) : 8'(n));
                for (int i = 0; i < n; i++) b.push_back(8'($urandom));
            end else repeat (4) b.push_back(8'($urandom));
            c = CRC_INIT;
            foreach (b[i]) c = crc_byte(c, b[i]);
            if (flaw == 4) c ^= 16'h0100;
            b.push_back(c[7:0]); b.push_back(c[15:8]);
        end
        if (flaw == 5) void'(b.pop_back());
        foreach (b[i]) send_item(MODE_BYTE, .rx(b[i]));
    endtask

    task automatic ticks(input int n);
        repeat (n) send_item(MODE_TICK);
    endtask

    task automatic start_req(input logic [7:0] fc, input logic [7:0] id,
                             input logic [15:0] ad, input logic [15:0] vl);
        cur_id = id;
        send_item(MODE_START, fc, id, ad, vl);
    endtask

    task automatic test_directed();
        set_config(16'd3, 16'd2, 16'd0, 3'd1, 6'd32);
        start_req(FC_HOLDING, 8'hFF, 16'hFFFF, 16'h0002); send_reply(FC_HOLDING, 2, 0);
        start_req(FC_COILS, 8'h00, 16'h0000, 16'h0009); send_reply(FC_COILS, 9, 0);
        start_req(FC_INPUTS, 8'h11, 16'h1234, 16'hFF01); send_reply(FC_INPUTS, 1, 1);
        start_req(FC_COIL_WR, 8'h01, 16'h00AA, 16'hFF00); send_reply(FC_COIL_WR, 0, 2);
        start_req(FC_REG_WR, 8'h7E, 16'h8001, 16'hFFFF); send_reply(FC_REG_WR, 0, 4);
        start_req(8'h10, 8'h01, 0, 0);                  // bad function
        start_req(FC_COILS, 8'h01, 0, 16'h0000);        // count zero
        start_req(FC_HOLDING, 8'h01, 0, 16'h00FF);      // register reply too long
        send_item(MODE_BYTE, .rx(8'h55));               // stray byte when idle
        send_item(MODE_TICK); send_item(MODE_NONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
        start_req(FC_HOLDING, 8'h05, 0, 16'h0001);
        start_req(FC_HOLDING, 8'h05, 0, 16'h0001);      // busy: ignored
        ticks(3);                                       // no reply
    endtask

    task automatic test_retries();
        set_config(16'd2, 16'd2, 16'd0, 3'd2, 6'd1);
        start_req(FC_COILS, 8'h02, 0, 16'h0009);        // exceeds small bit buffer
        start_req(FC_COILS, 8'h02, 0, 16'h0008);
        ticks(2); send_reply(FC_COILS, 8, 0);           // zero gap retry then ok
        set_config(16'd1, 16'd1, 16'd2, 3'd0, 6'd63);
        start_req(FC_INPUTS, 8'h03, 0, 16'h00C8);       // 200 inputs: 30-byte reply still fits
        start_req(FC_REG_WR, 8'h03, 0, 16'h1111); send_reply(FC_REG_WR, 0, 5); ticks(2);
        set_config(16'd2, 16'd1, 16'd2, 3'd3, 6'd32);
        start_req(FC_REG_WR, 8'h04, 0, 0);
        send_item(MODE_BYTE, .rx(8'h04)); ticks(1);     // partial, enter gap
        send_item(MODE_BYTE, .rx(8'h99)); ticks(2);     // byte during gap dropped
        send_reply(FC_REG_WR, 0, 0);
    endtask

    // Random exchanges: mostly well formed, some flawed, some noise
    task automatic test_random(input int n_runs);
        logic [7:0] fcs [5] = '{FC_COILS, FC_INPUTS, FC_HOLDING, FC_COIL_WR, FC_REG_WR};
        logic [7:0] fc, cnt;
        for (int r = 0; r < n_runs; r++) begin
            fc = fcs[$urandom_range(4)];
            cnt = (fc == FC_HOLDING) ? 8'($urandom_range(1, 6)) : 8'($urandom_range(1, 40));
            if ($urandom_range(9) == 0) begin
                start_req(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
            end else
                start_req(fc, 8'($urandom), 16'($urandom), {8'($urandom), cnt});
            case ($urandom_range(9))
                0: ticks($urandom_range(1, 4));
                1: send_item(MODE_NONE, 8'($urandom), 8'($urandom), 16'($urandom),
                             16'($urandom), 8'($urandom));
                default: send_reply(fc, cnt, ($urandom_range(2) == 0) ? $urandom_range(1, 5) : 0);
            endcase
            while (x_phase != X_IDLE) ticks(1);
        end
    endtask

    // Pressure: receiver holds off while a request is offered, forcing the block to stall
    task automatic test_backpressure();
        wait_drained();
        hold_off = 1'b1;
        start_req(FC_HOLDING, 8'h09, 16'h0010, 16'h0004);
        send_reply(FC_HOLDING, 4, 0);
        start_req(FC_COILS, 8'h09, 0, 16'h0010);
        send_reply(FC_COILS, 16, 0);
        hold_off = 1'b0;
    endtask

    // Receiver: random stalls, long hold-off counted in cycles
    initial begin
        int hold_cycles;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                hold_cycles = 0;
                i_ready <= 1'b0;
                while (hold_cycles < 400) begin
                    @(negedge i_clk); hold_cycles++;
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (expected_results.size() == 0) report_mismatch("unexpected result");
            else begin
                e = expected_results.pop_front();
                if (o_kind != e.kind) report_mismatch($sformatf("kind %0d exp %0d", o_kind, e.kind));
                if (o_tx_byte != e.tx) report_mismatch($sformatf("tx %h exp %h", o_tx_byte, e.tx));
                if (o_data_value != e.data)
                    report_mismatch($sformatf("data %h exp %h", o_data_value, e.data));
                if (o_status != e.st) report_mismatch($sformatf("status %0d exp %0d", o_status, e.st));
                if (o_exception_code != e.exc)
                    report_mismatch($sformatf("exc %h exp %h", o_exception_code, e.exc));
                if (o_last != e.last) report_mismatch($sformatf("last %b exp %b", o_last, e.last));
                if (e.kind == K_STAT) n_status++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_modbus_rtu_master_exchange_unit failed");
            $finish;
        end
    end

    initial begin
        cf_start_to = 16'd350; cf_byte_to = 16'd25; cf_gap = 16'd12;
        cf_max_att = 3'd2; cf_bitbuf = 6'd32;
        x_phase = X_IDLE; x_rcvd = 0; x_len = 0; x_crc = CRC_INIT; x_timer = 0; x_att = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_retries();
        set_config(16'd3, 16'd2, 16'd2, 3'd3, 6'd32);
        test_random(4);
        set_config(16'd2, 16'd2, 16'd1, 3'd2, 6'd32);
        send_idle_pct = 66; test_random(4);
        send_idle_pct = 0; recv_stall_pct = 66; test_random(4);
        send_idle_pct = 9; recv_stall_pct = 9; test_random(5);
        send_idle_pct = 0; recv_stall_pct = 0;
        test_backpressure();
        wait_drained();

        $display("covered %0d input transfers, %0d result transfers, %0d exchanges",
                 n_items, n_results, n_status);
        $display("all functions, error statuses, retries and timeout settings exercised");
        if (errors == 0) $display("tb_modbus_rtu_master_exchange_unit passed");
        else $display("tb_modbus_rtu_master_exchange_unit failed");
        $finish;
    end
endmodule
